[rtl/core/oklch_pkg.sv]
// ----------------------------------------------------------------------------
// oklch_pkg
// Shared types and constants for the OKLCH to linear RGB converter.
// ----------------------------------------------------------------------------
package oklch_pkg;

   // Field types
   typedef logic signed [17:0] q16s_type;
   typedef logic signed [15:0] hue_type;
   typedef logic        [16:0] q16u_type;

   // Hue constants in units of 1/64 degree
   localparam int HUE_FULL = 23040;
   localparam int HUE_QUAD = 5760;

   // CORDIC setup
   localparam int CORDIC_STEPS = 16;
   localparam int XW           = 33;
   localparam int ZW           = 32;
   localparam logic signed [XW-1:0] CORDIC_X0 = 33'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334
   };

   // Quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Fields that ride alongside the math pipeline
   typedef struct packed {
      logic       err;
      q16s_type   lig;
      q16s_type   chr;
      q16s_type   alp;
      logic [1:0] quad;
   } side_type;

endpackage

[rtl/core/oklch_if.sv]
// ----------------------------------------------------------------------------
// oklch_if
// Valid/ready channels for OKLCH items and linear RGB results.
// ----------------------------------------------------------------------------
interface oklch_req_if;
   import oklch_pkg::*;

   logic     valid;
   logic     ready;
   q16s_type lightness;
   q16s_type chroma;
   hue_type  hue_deg;
   q16s_type alpha_in;

   modport source (output valid, lightness, chroma, hue_deg, alpha_in, input ready);
   modport sink   (input valid, lightness, chroma, hue_deg, alpha_in, output ready);
endinterface

interface oklch_rsp_if;
   import oklch_pkg::*;

   logic     valid;
   logic     ready;
   q16u_type red;
   q16u_type green;
   q16u_type blue;
   q16u_type alpha_out;
   logic     range_error;

   modport source (output valid, red, green, blue, alpha_out, range_error, input ready);
   modport sink   (input valid, red, green, blue, alpha_out, range_error, output ready);
endinterface

[rtl/core/oklch_to_linear_rgb.sv]
// ----------------------------------------------------------------------------
// oklch_to_linear_rgb
// OKLCH to clamped linear RGB in a 23-stage pipeline with an output skid.
//
//   channel | dir | carries
//   --------+-----+-------------------------------------------------
//   req_ch  | in  | lightness, chroma, hue_deg, alpha_in
//   rsp_ch  | out | red, green, blue, alpha_out, range_error
//
// One item enters per clock while the skid is empty.
// Hue reduction, 16 CORDIC stages, rounding, then one multiply level per stage.
// Synchronous active-high reset clears the valid bits and the skid entry.
// A stalled response parks in a one-entry skid; the pipe freezes only while
// the skid holds an item, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module oklch_to_linear_rgb (
   input  logic         clock,
   input  logic         reset,
   oklch_req_if.sink    req_ch,
   oklch_rsp_if.source  rsp_ch
);
   import oklch_pkg::*;

   localparam int NSTG = 23;
   localparam int CS   = 1;          // first CORDIC output stage
   localparam int SC   = 17;         // sin/cos stage
   localparam int SA   = 18;         // a/b stage
   localparam int SL   = 19;         // LMS stage
   localparam int SQ   = 20;         // square stage
   localparam int SU   = 21;         // cube stage
   localparam int SO   = 22;         // output stage

   logic            adv;
   logic [NSTG-1:0] vld_ff;
   side_type        side_ff [SU+1];

   // ---------------- stage 0: range check and hue reduction ----------------
   logic signed [18:0] hue_t;
   logic        [14:0] hue_r;
   logic        [1:0]  quad_in;
   logic        [12:0] rem_in;
   logic               err_in;
   logic signed [XW-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [XW-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0] cz_ff [CORDIC_STEPS+1];

   always_comb begin
      hue_t = 19'(req_ch.hue_deg) + 19'sd46080;
      if (hue_t >= 19'sd69120) begin
         hue_r = 15'(hue_t - 19'sd69120);
      end else if (hue_t >= 19'sd46080) begin
         hue_r = 15'(hue_t - 19'sd46080);
      end else if (hue_t >= 19'sd23040) begin
         hue_r = 15'(hue_t - 19'sd23040);
      end else begin
         hue_r = 15'(hue_t);
      end
      if (hue_r >= 15'(3 * HUE_QUAD)) begin
         quad_in = QUAD_3;
         rem_in  = 13'(hue_r - 15'(3 * HUE_QUAD));
      end else if (hue_r >= 15'(2 * HUE_QUAD)) begin
         quad_in = QUAD_2;
         rem_in  = 13'(hue_r - 15'(2 * HUE_QUAD));
      end else if (hue_r >= 15'(HUE_QUAD)) begin
         quad_in = QUAD_1;
         rem_in  = 13'(hue_r - 15'(HUE_QUAD));
      end else begin
         quad_in = QUAD_0;
         rem_in  = 13'(hue_r);
      end
      err_in = (req_ch.lightness < 18'sd0) || (req_ch.lightness > 18'sd65536) ||
               (req_ch.chroma < 18'sd0) ||
               (req_ch.alpha_in < 18'sd0) || (req_ch.alpha_in > 18'sd65536);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{err: err_in, lig: req_ch.lightness, chr: req_ch.chroma,
                         alp: req_ch.alpha_in, quad: quad_in};
         cx_ff[0]   <= CORDIC_X0;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= $signed({3'b000, rem_in, 16'h0000});
      end
   end

   // ---------------- stages 1..16: one CORDIC rotation each ----------------
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[i+CS] <= side_ff[i];
            if (cz_ff[i] >= 0) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - ATAN_TAB[i];
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + ATAN_TAB[i];
            end
         end
      end
   end

   // ---------------- stage 17: round to Q16 and map quadrant ----------------
   logic signed [XW-1:0] xr, yr;
   logic signed [18:0]   c19, s19, co_in, si_in;
   logic signed [18:0]   co_ff, si_ff;

   always_comb begin
      xr  = cx_ff[CORDIC_STEPS] + 33'sd8192;
      yr  = cy_ff[CORDIC_STEPS] + 33'sd8192;
      c19 = xr[32:14];
      s19 = yr[32:14];
      case (side_ff[SC-1].quad)
         QUAD_0:  begin co_in = c19;  si_in = s19;  end
         QUAD_1:  begin co_in = -s19; si_in = c19;  end
         QUAD_2:  begin co_in = -c19; si_in = -s19; end
         QUAD_3:  begin co_in = s19;  si_in = -c19; end
         default: begin co_in = c19;  si_in = s19;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[SC] <= side_ff[SC-1];
         co_ff       <= co_in;
         si_ff       <= si_in;
      end
   end

   // ---------------- stage 18: a = C cos h, b = C sin h ----------------
   logic signed [39:0] pa, pb;
   logic signed [19:0] a_ff, b_ff;

   always_comb begin
      pa = 40'(side_ff[SC].chr) * 40'(co_ff) + 40'sd32768;
      pb = 40'(side_ff[SC].chr) * 40'(si_ff) + 40'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[SA] <= side_ff[SC];
         a_ff        <= pa[35:16];
         b_ff        <= pb[35:16];
      end
   end

   // ---------------- stage 19: OKLab to LMS ----------------
   logic signed [39:0] lig40, sl, sm, ss;
   logic signed [19:0] l_ff, m_ff, s_ff;

   always_comb begin
      lig40 = 40'(side_ff[SA].lig) <<< 16;
      sl = lig40 + 40'sd25974 * 40'(a_ff) + 40'sd14143 * 40'(b_ff) + 40'sd32768;
      sm = lig40 - 40'sd6918 * 40'(a_ff) - 40'sd4185 * 40'(b_ff) + 40'sd32768;
      ss = lig40 - 40'sd5864 * 40'(a_ff) - 40'sd84639 * 40'(b_ff) + 40'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[SL] <= side_ff[SA];
         l_ff        <= sl[35:16];
         m_ff        <= sm[35:16];
         s_ff        <= ss[35:16];
      end
   end

   // ---------------- stage 20: square ----------------
   logic signed [39:0] ql, qm, qs;
   logic signed [23:0] lsq_ff, msq_ff, ssq_ff;
   logic signed [19:0] l2_ff, m2_ff, s2_ff;

   always_comb begin
      ql = 40'(l_ff) * 40'(l_ff) + 40'sd32768;
      qm = 40'(m_ff) * 40'(m_ff) + 40'sd32768;
      qs = 40'(s_ff) * 40'(s_ff) + 40'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[SQ] <= side_ff[SL];
         lsq_ff      <= ql[39:16];
         msq_ff      <= qm[39:16];
         ssq_ff      <= qs[39:16];
         l2_ff       <= l_ff;
         m2_ff       <= m_ff;
         s2_ff       <= s_ff;
      end
   end

   // ---------------- stage 21: cube ----------------
   logic signed [43:0] ul, um, us;
   logic signed [27:0] l3_ff, m3_ff, s3_ff;

   always_comb begin
      ul = 44'(lsq_ff) * 44'(l2_ff) + 44'sd32768;
      um = 44'(msq_ff) * 44'(m2_ff) + 44'sd32768;
      us = 44'(ssq_ff) * 44'(s2_ff) + 44'sd32768;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[SU] <= side_ff[SQ];
         l3_ff       <= ul[43:16];
         m3_ff       <= um[43:16];
         s3_ff       <= us[43:16];
      end
   end

   // ---------------- stage 22: LMS to RGB, clamp, error mux ----------------
   logic signed [47:0] rs, gs, bs;
   q16u_type red_in, green_in, blue_in, alpha_in_q;
   q16u_type red_ff, green_ff, blue_ff, alpha_ff;
   logic     err_ff;

   function automatic q16u_type clamp1(input logic signed [47:0] v);
      logic signed [31:0] r;
      r = v[47:16];
      if (r < 32'sd0) begin
         return '0;
      end else if (r > 32'sd65536) begin
         return 17'd65536;
      end else begin
         return r[16:0];
      end
   endfunction

   always_comb begin
      rs = 48'sd267173 * 48'(l3_ff) - 48'sd216774 * 48'(m3_ff)
         + 48'sd15137 * 48'(s3_ff) + 48'sd32768;
      gs = -48'sd83128 * 48'(l3_ff) + 48'sd171033 * 48'(m3_ff)
         - 48'sd22369 * 48'(s3_ff) + 48'sd32768;
      bs = -48'sd275 * 48'(l3_ff) - 48'sd46099 * 48'(m3_ff)
         + 48'sd111910 * 48'(s3_ff) + 48'sd32768;
      if (side_ff[SU].err) begin
         red_in     = '0;
         green_in   = '0;
         blue_in    = '0;
         alpha_in_q = '0;
      end else begin
         red_in     = clamp1(rs);
         green_in   = clamp1(gs);
         blue_in    = clamp1(bs);
         alpha_in_q = side_ff[SU].alp[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in_q;
         err_ff   <= side_ff[SU].err;
      end
   end

   // ---------------- valid chain and output skid ----------------
   logic     skid_vld_ff;
   q16u_type skid_red_ff, skid_green_ff, skid_blue_ff, skid_alpha_ff;
   logic     skid_err_ff;

   assign adv          = !skid_vld_ff;
   assign req_ch.ready = adv;

   // advance valids with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_ch.valid};
      end
   end

   // park a refused result; drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_ch.ready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (vld_ff[SO] && !rsp_ch.ready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_red_ff   <= red_ff;
         skid_green_ff <= green_ff;
         skid_blue_ff  <= blue_ff;
         skid_alpha_ff <= alpha_ff;
         skid_err_ff   <= err_ff;
      end
   end

   // drive the response from the skid first
   assign rsp_ch.valid       = skid_vld_ff || vld_ff[SO];
   assign rsp_ch.red         = skid_vld_ff ? skid_red_ff   : red_ff;
   assign rsp_ch.green       = skid_vld_ff ? skid_green_ff : green_ff;
   assign rsp_ch.blue        = skid_vld_ff ? skid_blue_ff  : blue_ff;
   assign rsp_ch.alpha_out   = skid_vld_ff ? skid_alpha_ff : alpha_ff;
   assign rsp_ch.range_error = skid_vld_ff ? skid_err_ff   : err_ff;

endmodule

[bench/oklch_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oklch_tb_if
// Bench-side note: the channel interfaces come from the RTL interface file.
// This file only holds the bench-wide record type for one expected result.
// ----------------------------------------------------------------------------
package oklch_tb_pkg;
   import oklch_pkg::*;

   typedef struct packed {
      q16u_type red;
      q16u_type green;
      q16u_type blue;
      q16u_type alpha_out;
      logic     range_error;
   } rgb_result_type;

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OKLCH to linear RGB converter.
// Each accepted item is run through a bit-exact fixed-point model of the
// range check, CORDIC hue rotation, LMS cube and RGB matrix; every response
// is compared in order against the queued prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import oklch_pkg::*;
   import oklch_tb_pkg::*;

   localparam int LATENCY = 23;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   recv_hold = 1'b0;

   rgb_result_type expected_rgb [$];

   oklch_req_if req_ch ();
   oklch_rsp_if rsp_ch ();

   oklch_to_linear_rgb DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // Arithmetic shift and round half up
   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint cube_q16(longint v);
      longint sq;
      sq = round_q(v * v, 16);
      return round_q(sq * v, 16);
   endfunction

   function automatic q16u_type clamp_unit(longint v);
      if (v < 0) return '0;
      if (v > 65536) return 17'd65536;
      return q16u_type'(v);
   endfunction

   // Hue to cos/sin in Q16 via CORDIC with quadrant mapping
   task automatic hue_sincos(input longint hue, output longint co, output longint si);
      longint r, x, y, z, nx, c, s;
      logic [1:0] quad;
      r = hue % HUE_FULL;
      if (r < 0) r += HUE_FULL;
      quad = 2'(r / HUE_QUAD);
      z = (r % HUE_QUAD) * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      c = round_q(x, 14);
      s = round_q(y, 14);
      case (quad)
         QUAD_0: begin co = c;  si = s;  end
         QUAD_1: begin co = -s; si = c;  end
         QUAD_2: begin co = -c; si = -s; end
         default: begin co = s; si = -c; end
      endcase
   endtask

   // Predict the RGB result of one OKLCH item
   task automatic predict_rgb(input q16s_type lig, input q16s_type chr, input hue_type hue,
                              input q16s_type alp, output rgb_result_type res);
      longint L, C, A, co, si, a, b, l, m, s, l3, m3, s3;
      L = lig; C = chr; A = alp;
      res = '0;
      if (L < 0 || L > 65536 || C < 0 || A < 0 || A > 65536) begin
         res.range_error = 1'b1;
         return;
      end
      hue_sincos(longint'(hue), co, si);
      a = round_q(C * co, 16);
      b = round_q(C * si, 16);
      l = round_q(L * 65536 + 25974 * a + 14143 * b, 16);
      m = round_q(L * 65536 - 6918 * a - 4185 * b, 16);
      s = round_q(L * 65536 - 5864 * a - 84639 * b, 16);
      l3 = cube_q16(l);
      m3 = cube_q16(m);
      s3 = cube_q16(s);
      res.red   = clamp_unit(round_q(267173 * l3 - 216774 * m3 + 15137 * s3, 16));
      res.green = clamp_unit(round_q(-83128 * l3 + 171033 * m3 - 22369 * s3, 16));
      res.blue  = clamp_unit(round_q(-275 * l3 - 46099 * m3 + 111910 * s3, 16));
      res.alpha_out = q16u_type'(A);
   endtask

   // Offer one item, predict on acceptance; valid stays up for the next item
   task automatic send_color(input q16s_type lig, input q16s_type chr, input hue_type hue,
                             input q16s_type alp);
      rgb_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.lightness <= lig;
      req_ch.chroma    <= chr;
      req_ch.hue_deg   <= hue;
      req_ch.alpha_in  <= alp;
      do @(posedge clock); while (!req_ch.ready);
      predict_rgb(lig, chr, hue, alp, res);
      expected_rgb.push_back(res);
   endtask

   // Drop valid and hold until every expected result has come
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
   endtask

   // Receiver ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response against the oldest prediction
   always @(posedge clock) begin
      rgb_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rgb.size() == 0) begin
            $error("unexpected response item");
            errors++;
         end else begin
            exp_r = expected_rgb.pop_front();
            if (rsp_ch.red !== exp_r.red) begin
               $error("red exp %0d got %0d", exp_r.red, rsp_ch.red); errors++;
            end
            if (rsp_ch.green !== exp_r.green) begin
               $error("green exp %0d got %0d", exp_r.green, rsp_ch.green); errors++;
            end
            if (rsp_ch.blue !== exp_r.blue) begin
               $error("blue exp %0d got %0d", exp_r.blue, rsp_ch.blue); errors++;
            end
            if (rsp_ch.alpha_out !== exp_r.alpha_out) begin
               $error("alpha_out exp %0d got %0d", exp_r.alpha_out, rsp_ch.alpha_out);
               errors++;
            end
            if (rsp_ch.range_error !== exp_r.range_error) begin
               $error("range_error exp %0d got %0d", exp_r.range_error,
                      rsp_ch.range_error);
               errors++;
            end
         end
      end
   end

   // Extremes, error checks, hue wrap and channel clamping
   task automatic test_directed();
      send_color(18'sd0, 18'sd0, 16'sd0, 18'sd0);
      send_color(18'sd65536, 18'sd0, 16'sd0, 18'sd65536);
      send_color(-18'sd1, 18'sd0, 16'sd0, 18'sd65536);
      send_color(18'sd65537, 18'sd0, 16'sd0, 18'sd0);
      send_color(18'sd32768, -18'sd1, 16'sd0, 18'sd0);
      send_color(18'sd32768, 18'sd0, 16'sd0, -18'sd1);
      send_color(18'sd32768, 18'sd0, 16'sd0, 18'sd65537);
      send_color(-18'sd131072, -18'sd131072, -16'sd32768, -18'sd131072);
      send_color(18'sd131071, 18'sd131071, 16'sd32767, 18'sd131071);
      send_color(18'sd45000, 18'sd131071, -16'sd32768, 18'sd30000);
      send_color(18'sd45000, 18'sd131071, 16'sd32767, 18'sd30000);
      send_color(18'sd45000, 18'sd20000, -16'sd100, 18'sd65536);
      for (int q = 0; q < 8; q++)
         send_color(18'sd40000, 18'sd25000, hue_type'(q * 2880 - 1), 18'sd1000);
      send_color(18'sd65536, 18'sd131071, 16'sd1500, 18'sd65536);
      send_color(18'sd0, 18'sd131071, 16'sd9000, 18'sd0);
      send_color(18'sd20000, 18'sd0, 16'sd23040, 18'sd5);
   endtask

   // Random items, mostly in range, with out-of-range noise
   task automatic test_random(input int count);
      q16s_type lig, chr, alp;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8) begin
            lig = q16s_type'($urandom_range(65536));
            chr = q16s_type'($urandom_range(3) == 0 ? $urandom_range(131071)
                                                     : $urandom_range(30000));
            alp = q16s_type'($urandom_range(65536));
         end else begin
            lig = q16s_type'($urandom);
            chr = q16s_type'($urandom);
            alp = q16s_type'($urandom);
         end
         send_color(lig, chr, hue_type'($urandom), alp);
      end
   endtask

   // Hold the receiver so the pipe fills and the input stalls
   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (80) @(posedge clock);
            recv_hold = 1'b0;
         end
         test_random(60);
      join
      wait_drained();
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.lightness <= '0;
      req_ch.chroma    <= '0;
      req_ch.hue_deg   <= '0;
      req_ch.alpha_in  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      send_idle_pct = 23; recv_idle_pct = 47;
      test_random(550);
      wait_drained();
      send_idle_pct = 47; recv_idle_pct = 23;
      test_random(550);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(500);
      test_backpressure();

      wait_drained();
      repeat (LATENCY * 2) @(posedge clock);
      if (errors == 0 && expected_rgb.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/oklch_pkg.sv
rtl/core/oklch_if.sv
rtl/core/oklch_to_linear_rgb.sv
bench/oklch_tb_if.sv
bench/tb_top.sv
